// ===== hw/rtl/wcm_pkg.sv =====
// wcm_pkg: widths, codes and pipeline stage types of the waterfall colour map.
// Used by the channel interfaces and the waterfall_colour_map top level.
package wcm_pkg;

   localparam int IN_W   = 24;          // signed Q8.16 level and thresholds
   localparam int NW     = 24;          // offset and span of a level inside the ramp
   localparam int SW     = 28;          // nine times the offset
   localparam int DIFF_W = SW + 1;      // signed differences against span multiples
   localparam int XW     = 26;          // ramp numerator over four times the span
   localparam int QW     = 8;           // channel width and quotient bits
   localparam int NUM_W  = XW + QW;     // 255 times the numerator
   localparam int NDIV   = QW;          // divider stages, one quotient bit each

   localparam int CSR_W  = 32;
   localparam int ADDR_W = 3;
   localparam int REG_BIT = 2;

   localparam logic signed [IN_W-1:0] THR_LOW_RST  = 24'sd655;
   localparam logic signed [IN_W-1:0] THR_HIGH_RST = 24'sd64881;

   localparam logic [QW-1:0] CH_FULL = 8'hFF;
   localparam logic [QW-1:0] CH_ZERO = 8'h00;

   typedef enum logic {
      REG_THR_LOW  = 1'b0,
      REG_THR_HIGH = 1'b1
   } reg_idx_type;

   typedef enum logic [1:0] {
      KIND_BLACK = 2'd0,
      KIND_WHITE = 2'd1,
      KIND_RAMP  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      SEG_BLUE    = 3'd0,
      SEG_CYAN    = 3'd1,
      SEG_GREEN   = 3'd2,
      SEG_YELLOW  = 3'd3,
      SEG_RED     = 3'd4,
      SEG_MAGENTA = 3'd5,
      SEG_VIOLET  = 3'd6
   } seg_type;

   typedef struct packed {
      kind_type        kind;
      logic [NW-1:0]   n;
      logic [NW-1:0]   d;
   } s1_type;

   typedef struct packed {
      kind_type        kind;
      logic [SW-1:0]   s;
      logic [NW-1:0]   d;
      logic [SW-1:0]   d3;
      logic [SW-1:0]   d5;
      logic [SW-1:0]   d7;
   } s2_type;

   typedef struct packed {
      kind_type        kind;
      seg_type         seg;
      logic [NW-1:0]   d;
      logic [XW-1:0]   p_blue;
      logic [XW-1:0]   p_cyan;
      logic [XW-1:0]   p_green;
      logic [XW-1:0]   p_yellow;
      logic [XW-1:0]   p_red;
      logic [XW-1:0]   p_magenta;
      logic [XW-1:0]   p_violet_r;
      logic [XW-1:0]   p_violet_g;
   } s3_type;

   typedef struct packed {
      kind_type        kind;
      seg_type         seg;
      logic [NW-1:0]   d;
      logic [XW-1:0]   xa;
      logic [XW-1:0]   xb;
   } s4_type;

   typedef struct packed {
      kind_type         kind;
      seg_type          seg;
      logic [XW-1:0]    dsr;
      logic [NUM_W-1:0] rem_a;
      logic [NUM_W-1:0] rem_b;
      logic [QW-1:0]    qa;
      logic [QW-1:0]    qb;
   } div_type;

endpackage

// ===== hw/rtl/wcm_req_if.sv =====
// wcm_req_if: input beat channel carrying one signed Q8.16 level.
// Depends on wcm_pkg for the field width.
interface wcm_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [wcm_pkg::IN_W-1:0]    value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/wcm_rsp_if.sv =====
// wcm_rsp_if: result beat channel carrying one RGB pixel.
// Depends on wcm_pkg for the channel width.
interface wcm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wcm_pkg::QW-1:0]      red;
   logic [wcm_pkg::QW-1:0]      green;
   logic [wcm_pkg::QW-1:0]      blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/waterfall_colour_map.sv =====
// waterfall_colour_map: maps each signed Q8.16 level to an RGB pixel through seven linear
// segments between two thresholds set over an APB-style port; uses wcm_pkg, wcm_req_if and
// wcm_rsp_if. One beat enters per clock while req ready is high, and the depth is
// set by an 8-stage restoring divider that yields one quotient bit per stage. Each stage
// holds only while the stage after it is full and stalled, so bubbles close up and req
// ready drops only when every stage holds a beat and the output is not taken.
module waterfall_colour_map (
   input  logic                          clock,
   input  logic                          reset,
   wcm_req_if.sink                       req_bus,
   wcm_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wcm_pkg::ADDR_W-1:0]    paddr,
   input  logic [wcm_pkg::CSR_W-1:0]     pwdata,
   output logic [wcm_pkg::CSR_W-1:0]     prdata,
   output logic                          pready
);

   localparam int ST_S1  = 0;
   localparam int ST_S2  = 1;
   localparam int ST_S3  = 2;
   localparam int ST_S4  = 3;
   localparam int ST_DIV = 4;
   localparam int ST_OUT = ST_DIV + wcm_pkg::NDIV + 1;
   localparam int NSTG   = ST_OUT + 1;

   logic signed [wcm_pkg::IN_W-1:0] thr_low_ff;
   logic signed [wcm_pkg::IN_W-1:0] thr_high_ff;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   wcm_pkg::s1_type  s1_ff, s1_in;
   wcm_pkg::s2_type  s2_ff, s2_in;
   wcm_pkg::s3_type  s3_ff, s3_in;
   wcm_pkg::s4_type  s4_ff, s4_in;
   wcm_pkg::div_type div_ff [wcm_pkg::NDIV+1];
   wcm_pkg::div_type div_in [wcm_pkg::NDIV+1];

   logic [wcm_pkg::QW-1:0] red_ff, red_in;
   logic [wcm_pkg::QW-1:0] green_ff, green_in;
   logic [wcm_pkg::QW-1:0] blue_ff, blue_in;

   // configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_low_ff  <= wcm_pkg::THR_LOW_RST;
         thr_high_ff <= wcm_pkg::THR_HIGH_RST;
      end else if (psel && penable && pwrite && pready) begin
         case (wcm_pkg::reg_idx_type'(paddr[wcm_pkg::REG_BIT]))
            wcm_pkg::REG_THR_LOW:  thr_low_ff  <= pwdata[wcm_pkg::IN_W-1:0];
            wcm_pkg::REG_THR_HIGH: thr_high_ff <= pwdata[wcm_pkg::IN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wcm_pkg::reg_idx_type'(paddr[wcm_pkg::REG_BIT]))
         wcm_pkg::REG_THR_LOW:
            prdata = {{(wcm_pkg::CSR_W-wcm_pkg::IN_W){thr_low_ff[wcm_pkg::IN_W-1]}},
                      thr_low_ff};
         wcm_pkg::REG_THR_HIGH:
            prdata = {{(wcm_pkg::CSR_W-wcm_pkg::IN_W){thr_high_ff[wcm_pkg::IN_W-1]}},
                      thr_high_ff};
         default:
            prdata = '0;
      endcase
   end

   // stage flow: a stage loads when empty or when the next one loads
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_bus.ready;
      for (int i = NSTG-2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = req_bus.valid;
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_bus.ready = en[ST_S1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // stage 1: offset, span and clip class
   always_comb begin
      logic signed [wcm_pkg::IN_W:0] diff_v;
      logic signed [wcm_pkg::IN_W:0] diff_s;
      diff_v = {req_bus.value[wcm_pkg::IN_W-1], req_bus.value}
             - {thr_low_ff[wcm_pkg::IN_W-1], thr_low_ff};
      diff_s = {thr_high_ff[wcm_pkg::IN_W-1], thr_high_ff}
             - {thr_low_ff[wcm_pkg::IN_W-1], thr_low_ff};
      if (diff_v[wcm_pkg::IN_W]) begin
         s1_in.kind = wcm_pkg::KIND_BLACK;
      end else if (req_bus.value > thr_high_ff) begin
         s1_in.kind = wcm_pkg::KIND_WHITE;
      end else if (thr_high_ff == thr_low_ff) begin
         s1_in.kind = wcm_pkg::KIND_BLACK;
      end else begin
         s1_in.kind = wcm_pkg::KIND_RAMP;
      end
      s1_in.n = diff_v[wcm_pkg::NW-1:0];
      s1_in.d = diff_s[wcm_pkg::NW-1:0];
   end

   // stage 2: nine times the offset and odd span multiples
   always_comb begin
      s2_in.kind = s1_ff.kind;
      s2_in.d    = s1_ff.d;
      s2_in.s    = wcm_pkg::SW'({s1_ff.n, 3'b000}) + wcm_pkg::SW'(s1_ff.n);
      s2_in.d3   = wcm_pkg::SW'({s1_ff.d, 1'b0}) + wcm_pkg::SW'(s1_ff.d);
      s2_in.d5   = wcm_pkg::SW'({s1_ff.d, 2'b00}) + wcm_pkg::SW'(s1_ff.d);
      s2_in.d7   = wcm_pkg::SW'({s1_ff.d, 3'b000}) - wcm_pkg::SW'(s1_ff.d);
   end

   // stage 3: segment boundaries and candidate numerators over four spans
   always_comb begin
      logic signed [wcm_pkg::DIFF_W-1:0] s_x, d2_x, d3_x, d4_x, d5_x, d7_x, d8_x, d12_x;
      logic signed [wcm_pkg::DIFF_W-1:0] t2, t3, t4, t5, t7, t8, u4, u7, u12;
      s_x   = wcm_pkg::DIFF_W'(s2_ff.s);
      d2_x  = wcm_pkg::DIFF_W'({s2_ff.d, 1'b0});
      d3_x  = wcm_pkg::DIFF_W'(s2_ff.d3);
      d4_x  = wcm_pkg::DIFF_W'({s2_ff.d, 2'b00});
      d5_x  = wcm_pkg::DIFF_W'(s2_ff.d5);
      d7_x  = wcm_pkg::DIFF_W'(s2_ff.d7);
      d8_x  = wcm_pkg::DIFF_W'({s2_ff.d, 3'b000});
      d12_x = wcm_pkg::DIFF_W'({s2_ff.d3, 2'b00});
      t2  = s_x - d2_x;
      t3  = s_x - d3_x;
      t4  = s_x - d4_x;
      t5  = s_x - d5_x;
      t7  = s_x - d7_x;
      t8  = s_x - d8_x;
      u4  = d4_x - s_x;
      u7  = d7_x - s_x;
      u12 = d12_x - s_x;

      s3_in.kind = s2_ff.kind;
      s3_in.d    = s2_ff.d;
      if (t2[wcm_pkg::DIFF_W-1]) begin
         s3_in.seg = wcm_pkg::SEG_BLUE;
      end else if (t3[wcm_pkg::DIFF_W-1]) begin
         s3_in.seg = wcm_pkg::SEG_CYAN;
      end else if (t4[wcm_pkg::DIFF_W-1]) begin
         s3_in.seg = wcm_pkg::SEG_GREEN;
      end else if (t5[wcm_pkg::DIFF_W-1]) begin
         s3_in.seg = wcm_pkg::SEG_YELLOW;
      end else if (t7[wcm_pkg::DIFF_W-1]) begin
         s3_in.seg = wcm_pkg::SEG_RED;
      end else if (t8[wcm_pkg::DIFF_W-1]) begin
         s3_in.seg = wcm_pkg::SEG_MAGENTA;
      end else begin
         s3_in.seg = wcm_pkg::SEG_VIOLET;
      end
      s3_in.p_blue     = {s_x[wcm_pkg::XW-2:0], 1'b0};
      s3_in.p_cyan     = {t2[wcm_pkg::XW-3:0], 2'b00};
      s3_in.p_green    = {u4[wcm_pkg::XW-3:0], 2'b00};
      s3_in.p_yellow   = {t4[wcm_pkg::XW-3:0], 2'b00};
      s3_in.p_red      = {u7[wcm_pkg::XW-2:0], 1'b0};
      s3_in.p_magenta  = {t7[wcm_pkg::XW-3:0], 2'b00};
      s3_in.p_violet_r = u12[wcm_pkg::XW-1:0];
      s3_in.p_violet_g = {t8[wcm_pkg::XW-2:0], 1'b0};
   end

   // stage 4: select numerators of the ramping channels
   always_comb begin
      s4_in.kind = s3_ff.kind;
      s4_in.seg  = s3_ff.seg;
      s4_in.d    = s3_ff.d;
      s4_in.xb   = '0;
      case (s3_ff.seg)
         wcm_pkg::SEG_BLUE:    s4_in.xa = s3_ff.p_blue;
         wcm_pkg::SEG_CYAN:    s4_in.xa = s3_ff.p_cyan;
         wcm_pkg::SEG_GREEN:   s4_in.xa = s3_ff.p_green;
         wcm_pkg::SEG_YELLOW:  s4_in.xa = s3_ff.p_yellow;
         wcm_pkg::SEG_RED:     s4_in.xa = s3_ff.p_red;
         wcm_pkg::SEG_MAGENTA: s4_in.xa = s3_ff.p_magenta;
         wcm_pkg::SEG_VIOLET: begin
            s4_in.xa = s3_ff.p_violet_r;
            s4_in.xb = s3_ff.p_violet_g;
         end
         default:              s4_in.xa = '0;
      endcase
   end

   // divider entry and quotient bit stages
   always_comb begin
      logic [wcm_pkg::NUM_W-1:0] trial;
      div_in[0].kind  = s4_ff.kind;
      div_in[0].seg   = s4_ff.seg;
      div_in[0].dsr   = {s4_ff.d, 2'b00};
      div_in[0].rem_a = {s4_ff.xa, {wcm_pkg::QW{1'b0}}} - wcm_pkg::NUM_W'(s4_ff.xa);
      div_in[0].rem_b = {s4_ff.xb, {wcm_pkg::QW{1'b0}}} - wcm_pkg::NUM_W'(s4_ff.xb);
      div_in[0].qa    = '0;
      div_in[0].qb    = '0;
      for (int j = 0; j < wcm_pkg::NDIV; j++) begin
         trial = wcm_pkg::NUM_W'(div_ff[j].dsr) << (wcm_pkg::QW-1-j);
         div_in[j+1] = div_ff[j];
         if (div_ff[j].rem_a >= trial) begin
            div_in[j+1].rem_a = div_ff[j].rem_a - trial;
            div_in[j+1].qa[wcm_pkg::QW-1-j] = 1'b1;
         end
         if (div_ff[j].rem_b >= trial) begin
            div_in[j+1].rem_b = div_ff[j].rem_b - trial;
            div_in[j+1].qb[wcm_pkg::QW-1-j] = 1'b1;
         end
      end
   end

   // output stage: place quotients on their channels
   always_comb begin
      logic [wcm_pkg::QW-1:0] qa;
      logic [wcm_pkg::QW-1:0] qb;
      qa = div_ff[wcm_pkg::NDIV].qa;
      qb = div_ff[wcm_pkg::NDIV].qb;
      red_in   = wcm_pkg::CH_ZERO;
      green_in = wcm_pkg::CH_ZERO;
      blue_in  = wcm_pkg::CH_ZERO;
      case (div_ff[wcm_pkg::NDIV].kind)
         wcm_pkg::KIND_WHITE: begin
            red_in   = wcm_pkg::CH_FULL;
            green_in = wcm_pkg::CH_FULL;
            blue_in  = wcm_pkg::CH_FULL;
         end
         wcm_pkg::KIND_RAMP: begin
            case (div_ff[wcm_pkg::NDIV].seg)
               wcm_pkg::SEG_BLUE: begin
                  blue_in = qa;
               end
               wcm_pkg::SEG_CYAN: begin
                  green_in = qa;
                  blue_in  = wcm_pkg::CH_FULL;
               end
               wcm_pkg::SEG_GREEN: begin
                  green_in = wcm_pkg::CH_FULL;
                  blue_in  = qa;
               end
               wcm_pkg::SEG_YELLOW: begin
                  red_in   = qa;
                  green_in = wcm_pkg::CH_FULL;
               end
               wcm_pkg::SEG_RED: begin
                  red_in   = wcm_pkg::CH_FULL;
                  green_in = qa;
               end
               wcm_pkg::SEG_MAGENTA: begin
                  red_in  = wcm_pkg::CH_FULL;
                  blue_in = qa;
               end
               wcm_pkg::SEG_VIOLET: begin
                  red_in   = qa;
                  green_in = qb;
                  blue_in  = wcm_pkg::CH_FULL;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[ST_S1]) begin
         s1_ff <= s1_in;
      end
      if (en[ST_S2]) begin
         s2_ff <= s2_in;
      end
      if (en[ST_S3]) begin
         s3_ff <= s3_in;
      end
      if (en[ST_S4]) begin
         s4_ff <= s4_in;
      end
      for (int j = 0; j <= wcm_pkg::NDIV; j++) begin
         if (en[ST_DIV+j]) begin
            div_ff[j] <= div_in[j];
         end
      end
      if (en[ST_OUT]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_bus.valid = vld_ff[ST_OUT];
   assign rsp_bus.red   = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue  = blue_ff;

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&vld_ff) && !rsp_bus.ready)
      else $error("input stalled while a stage was free");

   a_ramp_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_S1] && s1_ff.kind == wcm_pkg::KIND_RAMP |-> s1_ff.d != '0)
      else $error("zero span reached the ramp path");

   a_numerator_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_S4] && s4_ff.kind == wcm_pkg::KIND_RAMP
      |-> s4_ff.xa <= {s4_ff.d, 2'b00} && s4_ff.xb <= {s4_ff.d, 2'b00})
      else $error("ramp numerator exceeds four spans");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT-1] && div_ff[wcm_pkg::NDIV].kind == wcm_pkg::KIND_RAMP
      |-> div_ff[wcm_pkg::NDIV].rem_a < wcm_pkg::NUM_W'(div_ff[wcm_pkg::NDIV].dsr)
       && div_ff[wcm_pkg::NDIV].rem_b < wcm_pkg::NUM_W'(div_ff[wcm_pkg::NDIV].dsr))
      else $error("divider remainder not below divisor");

endmodule

// ===== dv/waterfall_colour_map_test.sv =====
// Self-checking testbench for waterfall_colour_map: a directed table, then random levels
// across several threshold settings, each pixel compared with a table row or a built-in colour predictor.
// Depends on wcm_pkg, wcm_req_if, wcm_rsp_if and the waterfall_colour_map RTL.
module waterfall_colour_map_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVEL_MIN = -8388608;
   localparam int LEVEL_MAX = 8388607;
   localparam int BEATS_PER_PHASE = 50;
   localparam int RANDOM_PHASES = 8;
   localparam int STEADY_PHASE = 2;
   localparam int LATENCY_SLACK = 20;

   typedef struct packed {
      logic [wcm_pkg::QW-1:0] red;
      logic [wcm_pkg::QW-1:0] green;
      logic [wcm_pkg::QW-1:0] blue;
   } pixel_type;

   typedef struct packed {
      int lo;
      int hi;
      int level;
      bit typed;
      int red;
      int green;
      int blue;
   } level_row_type;

   typedef enum int {
      SPAN_WIDE,
      SPAN_NARROW,
      SPAN_FULL,
      SPAN_NONE,
      SPAN_CROSSED,
      SPAN_TYPICAL
   } span_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [wcm_pkg::ADDR_W-1:0] paddr;
   logic [wcm_pkg::CSR_W-1:0] pwdata;
   logic [wcm_pkg::CSR_W-1:0] prdata;
   logic pready;

   wcm_req_if req_bus ();
   wcm_rsp_if rsp_bus ();

   int thr_low;
   int thr_high;
   bit steady;
   int failures;
   pixel_type pending_pixels[$];
   pixel_type want;

   level_row_type directed_rows [24] = '{
      '{655, 64881, -8388608, 1'b1, 0, 0, 0},
      '{655, 64881, 654, 1'b1, 0, 0, 0},
      '{655, 64881, 655, 1'b1, 0, 0, 0},
      '{655, 64881, 14927, 1'b0, 0, 0, 0},
      '{655, 64881, 14928, 1'b0, 0, 0, 0},
      '{655, 64881, 22064, 1'b0, 0, 0, 0},
      '{655, 64881, 29201, 1'b0, 0, 0, 0},
      '{655, 64881, 36337, 1'b0, 0, 0, 0},
      '{655, 64881, 50609, 1'b0, 0, 0, 0},
      '{655, 64881, 57745, 1'b0, 0, 0, 0},
      '{655, 64881, 64881, 1'b1, 191, 127, 255},
      '{655, 64881, 64882, 1'b1, 255, 255, 255},
      '{655, 64881, 8388607, 1'b1, 255, 255, 255},
      '{100, 100, 99, 1'b1, 0, 0, 0},
      '{100, 100, 100, 1'b1, 0, 0, 0},
      '{100, 100, 101, 1'b1, 255, 255, 255},
      '{1000, -1000, 0, 1'b1, 0, 0, 0},
      '{1000, -1000, 1000, 1'b1, 255, 255, 255},
      '{-8388608, 8388607, -8388608, 1'b1, 0, 0, 0},
      '{-8388608, 8388607, -1, 1'b0, 0, 0, 0},
      '{-8388608, 8388607, 8388607, 1'b1, 191, 127, 255},
      '{0, 9, 2, 1'b0, 0, 0, 0},
      '{0, 9, 5, 1'b0, 0, 0, 0},
      '{0, 9, 8, 1'b0, 0, 0, 0}
   };

   waterfall_colour_map u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #6 clock = ~clock;

   function automatic logic [wcm_pkg::QW-1:0] ramp255(input longint unsigned num,
                                                      input longint unsigned den);
      longint unsigned q;
      q = (255 * num) / den;
      return (q > 255) ? wcm_pkg::CH_FULL : q[wcm_pkg::QW-1:0];
   endfunction

   function automatic pixel_type colour_of(input int level, input int lo, input int hi);
      longint unsigned n;
      longint unsigned d;
      longint unsigned s;
      longint unsigned top;
      pixel_type px;
      px = '{red: wcm_pkg::CH_ZERO, green: wcm_pkg::CH_ZERO, blue: wcm_pkg::CH_ZERO};
      if (level < lo) return px;
      if (level > hi)
         return '{red: wcm_pkg::CH_FULL, green: wcm_pkg::CH_FULL, blue: wcm_pkg::CH_FULL};
      if (lo == hi) return px;
      n = longint'(level) - longint'(lo);
      d = longint'(hi) - longint'(lo);
      s = 9 * n;
      if (s < 2 * d) begin
         px.blue = ramp255(s, 2 * d);
      end else if (s < 3 * d) begin
         px.green = ramp255(s - 2 * d, d);
         px.blue = wcm_pkg::CH_FULL;
      end else if (s < 4 * d) begin
         px.green = wcm_pkg::CH_FULL;
         px.blue = ramp255(4 * d - s, d);
      end else if (s < 5 * d) begin
         px.red = ramp255(s - 4 * d, d);
         px.green = wcm_pkg::CH_FULL;
      end else if (s < 7 * d) begin
         px.red = wcm_pkg::CH_FULL;
         px.green = ramp255(7 * d - s, 2 * d);
      end else if (s < 8 * d) begin
         px.red = wcm_pkg::CH_FULL;
         px.blue = ramp255(s - 7 * d, d);
      end else begin
         top = 12 * d;
         px.red = ramp255((top > s) ? top - s : 0, 4 * d);
         px.green = ramp255(s - 8 * d, 2 * d);
         px.blue = wcm_pkg::CH_FULL;
      end
      return px;
   endfunction

   function automatic int clip24(input longint x);
      if (x < LEVEL_MIN) return LEVEL_MIN;
      if (x > LEVEL_MAX) return LEVEL_MAX;
      return int'(x);
   endfunction

   function automatic int rand_level24();
      logic signed [wcm_pkg::IN_W-1:0] raw;
      raw = wcm_pkg::IN_W'($urandom);
      return int'(raw);
   endfunction

   function automatic int pick_level();
      int roll;
      int jitter;
      roll = $urandom_range(99);
      jitter = int'($urandom_range(4)) - 2;
      if (roll < 70 && thr_low <= thr_high)
         return int'(longint'(thr_low) + longint'($urandom_range(thr_high - thr_low)));
      if (roll < 85)
         return clip24(longint'(roll[0] ? thr_low : thr_high) + jitter);
      return rand_level24();
   endfunction

   task automatic send_level(input int level, input pixel_type px);
      int gaps;
      gaps = 0;
      while (!steady && $urandom_range(99) < 25) gaps++;
      if (gaps > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= level[wcm_pkg::IN_W-1:0];
      do @(posedge clock); while (!req_bus.ready);
      pending_pixels.push_back(px);
      @(negedge clock);
   endtask

   task automatic settle_pipeline();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_threshold(input wcm_pkg::reg_idx_type idx, input int level);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= wcm_pkg::ADDR_W'(int'(idx) << wcm_pkg::REG_BIT);
      pwdata <= level;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_thresholds(input int lo, input int hi);
      write_threshold(wcm_pkg::REG_THR_LOW, lo);
      thr_low = lo;
      write_threshold(wcm_pkg::REG_THR_HIGH, hi);
      thr_high = hi;
   endtask

   task automatic compare_channel(input string name, input logic [wcm_pkg::QW-1:0] exp_v,
                                  input logic [wcm_pkg::QW-1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel beat with none pending: red %0d green %0d blue %0d",
                   rsp_bus.red, rsp_bus.green, rsp_bus.blue);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            compare_channel("red", want.red, rsp_bus.red);
            compare_channel("green", want.green, rsp_bus.green);
            compare_channel("blue", want.blue, rsp_bus.blue);
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      level_row_type row;
      span_kind_type kind;
      int lo;
      int hi;
      int swap;
      pixel_type px;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      steady = 1'b0;
      failures = 0;
      thr_low = int'(wcm_pkg::THR_LOW_RST);
      thr_high = int'(wcm_pkg::THR_HIGH_RST);
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.lo != thr_low || row.hi != thr_high) begin
            settle_pipeline();
            program_thresholds(row.lo, row.hi);
         end
         if (row.typed)
            px = '{red: row.red[wcm_pkg::QW-1:0], green: row.green[wcm_pkg::QW-1:0],
                   blue: row.blue[wcm_pkg::QW-1:0]};
         else
            px = colour_of(row.level, thr_low, thr_high);
         send_level(row.level, px);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind = span_kind_type'((phase <= int'(SPAN_TYPICAL)) ? phase : $urandom_range(5));
         lo = rand_level24();
         hi = rand_level24();
         case (kind)
            SPAN_WIDE: begin
               if (lo > hi) begin
                  swap = lo;
                  lo = hi;
                  hi = swap;
               end
            end
            SPAN_NARROW: hi = clip24(longint'(lo) + $urandom_range(20, 1));
            SPAN_FULL: begin
               lo = LEVEL_MIN;
               hi = LEVEL_MAX;
            end
            SPAN_NONE: hi = lo;
            SPAN_CROSSED: begin
               if (lo < hi) begin
                  swap = lo;
                  lo = hi;
                  hi = swap;
               end
            end
            default: hi = clip24(longint'(lo) + $urandom_range(70000, 1));
         endcase
         settle_pipeline();
         program_thresholds(lo, hi);
         steady = (phase == STEADY_PHASE);
         repeat (BEATS_PER_PHASE) begin
            lo = pick_level();
            send_level(lo, colour_of(lo, thr_low, thr_high));
         end
      end

      steady = 1'b0;
      settle_pipeline();
      repeat (LATENCY_SLACK) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
